FILE: sv/pcg_pkg.sv
// Shared constants, types and the output permutation of the PCG32 generator.
`default_nettype none
package pcg_pkg;

	localparam int unsigned VAL_W  = 64;
	localparam int unsigned HALF_W = VAL_W / 2;
	localparam int unsigned SEQ_W  = 63;
	localparam int unsigned ADDR_W = 4;

	localparam logic [VAL_W-1:0] PCG_MULT  = 64'd6364136223846793005;
	localparam logic [SEQ_W-1:0] RESET_SEQ = 63'd721347520444481703;
	localparam logic [VAL_W-1:0] RESET_SEED = '0;
	localparam logic [VAL_W-1:0] RESET_INC = {RESET_SEQ, 1'b1};
	// Reseed from the reset registers: the first step from zero leaves the increment,
	// the seed of zero adds nothing, and the second step is folded in here.
	localparam logic [VAL_W-1:0] RESET_STATE = RESET_INC * PCG_MULT + RESET_INC;

	localparam int unsigned XSH_SHIFT = 18;
	localparam int unsigned XSH_LSB   = 27;
	localparam int unsigned ROT_LSB   = 59;

	// Register index, taken from address bit 3.
	localparam logic REG_SEED   = 1'b0;
	localparam logic REG_STREAM = 1'b1;

	typedef enum logic [1:0] {
		OP_RESEED  = 2'd0,
		OP_NEXT32  = 2'd1,
		OP_NEXT64  = 2'd2,
		OP_BOUNDED = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_MUL_WAIT,
		ST_THRESH,
		ST_THRESH_WAIT,
		ST_CHECK,
		ST_MOD_WAIT,
		ST_DONE
	} fsm_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	function automatic logic [HALF_W-1:0] xsh_rr(input logic [VAL_W-1:0] old);
		logic [VAL_W-1:0]    mixed_full;
		logic [HALF_W-1:0]   mixed;
		logic [4:0]          rot;
		logic [2*HALF_W-1:0] dbl;
		mixed_full = (old >> XSH_SHIFT) ^ old;
		mixed      = mixed_full[XSH_LSB +: HALF_W];
		rot        = old[ROT_LSB +: 5];
		dbl        = {mixed, mixed} >> rot;
		return dbl[HALF_W-1:0];
	endfunction

endpackage
`default_nettype wire

FILE: sv/pcg_mul.sv
// LCG step unit: state * multiplier + increment over one shared 32x32 multiplier.
`default_nettype none
module pcg_mul (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [pcg_pkg::VAL_W-1:0] state,
	input  wire logic [pcg_pkg::VAL_W-1:0] inc,
	output pcg_pkg::unit_stat_t            stat,
	output logic      [pcg_pkg::VAL_W-1:0] result
);

	localparam int unsigned HW = pcg_pkg::HALF_W;

	logic            busy_q, done_q;
	logic [1:0]      cnt_q;
	logic [2*HW-1:0] a_q, c_q, acc_q, prod_q;
	logic [HW-1:0]   opa, opb;
	logic [2*HW-1:0] prod;

	// Only the low 64 bits of the product matter, so the high-by-high term is skipped.
	always_comb begin
		unique case (cnt_q)
			2'd0: begin
				opa = a_q[HW-1:0];
				opb = pcg_pkg::PCG_MULT[HW-1:0];
			end
			2'd1: begin
				opa = a_q[HW-1:0];
				opb = pcg_pkg::PCG_MULT[2*HW-1:HW];
			end
			2'd2: begin
				opa = a_q[2*HW-1:HW];
				opb = pcg_pkg::PCG_MULT[HW-1:0];
			end
			2'd3: begin
				opa = a_q[HW-1:0];
				opb = pcg_pkg::PCG_MULT[HW-1:0];
			end
		endcase
	end

	assign prod = opa * opb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= state;
			c_q <= inc;
		end else if (busy_q) begin
			prod_q <= prod;
			unique case (cnt_q)
				2'd0: acc_q <= acc_q;
				2'd1: acc_q <= c_q + prod_q;
				2'd2: acc_q <= acc_q + {prod_q[HW-1:0], {HW{1'b0}}};
				2'd3: acc_q <= acc_q + {prod_q[HW-1:0], {HW{1'b0}}};
			endcase
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign result    = acc_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("step unit finished without having been busy");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start)
		else $error("step unit started while busy");
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> cnt_q == 2'd0)
		else $error("step unit count did not wrap at the end");

endmodule
`default_nettype wire

FILE: sv/pcg_div.sv
// Bit-serial remainder unit: num mod den, one quotient bit a cycle.
`default_nettype none
module pcg_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [pcg_pkg::VAL_W-1:0] num,
	input  wire logic [pcg_pkg::VAL_W-1:0] den,
	output pcg_pkg::unit_stat_t            stat,
	output logic      [pcg_pkg::VAL_W-1:0] rem
);

	localparam int unsigned W     = pcg_pkg::VAL_W;
	localparam int unsigned CNT_W = $clog2(W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(W - 1);

	logic             busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     rem_q, num_q, den_q;
	logic [W:0]       shifted, trial;

	assign shifted = {rem_q, num_q[W-1]};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The partial remainder stays below den, so a kept difference fits in W bits.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			num_q <= {num_q[W-2:0], 1'b0};
			if (!trial[W])
				rem_q <= trial[W-1:0];
			else
				rem_q <= shifted[W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign rem       = rem_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("remainder unit finished without having been busy");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start)
		else $error("remainder unit started while busy");
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < den_q)
		else $error("remainder not below divisor");

endmodule
`default_nettype wire

FILE: sv/pcg32_generator_bounded.sv
// Top level of the PCG32 XSH-RR generator with bounded draws and its register port.
// Each step runs on the shared 32x32 multiplier. A bounded draw adds two passes of the
// remainder unit and a fresh 64-bit draw for each rejected draw. One item at a time:
// the next beat is taken after the result is loaded.
// Reset loads the registers with their reset values and the state as if reseeded.
`default_nettype none
module pcg32_generator_bounded (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [pcg_pkg::ADDR_W-1:0] paddr,
	input  wire logic [pcg_pkg::VAL_W-1:0]  pwdata,
	output logic      [pcg_pkg::VAL_W-1:0]  prdata,
	output logic                            pready,
	input  wire logic                       req_valid,
	output logic                            req_stall,
	input  wire logic [1:0]                 op,
	input  wire logic [pcg_pkg::VAL_W-1:0]  bound,
	output logic                            rsp_valid,
	input  wire logic                       rsp_stall,
	output logic      [pcg_pkg::VAL_W-1:0]  value,
	output logic                            status
);

	localparam int unsigned W  = pcg_pkg::VAL_W;
	localparam int unsigned HW = pcg_pkg::HALF_W;

	pcg_pkg::fsm_t     state_q, state_d;
	pcg_pkg::op_t      op_q;
	pcg_pkg::unit_stat_t mul_st, div_st;

	logic [W-1:0]                seed_q, lcg_q, inc_q;
	logic [pcg_pkg::SEQ_W-1:0]   stream_q;
	logic [W-1:0]                bound_q, draw_q, thresh_q, res_value_q;
	logic                        res_status_q, more_q;
	logic [W-1:0]                rsp_value_q;
	logic                        rsp_valid_q, rsp_status_q;

	logic [W-1:0]  mul_result, div_rem, div_num;
	logic [HW-1:0] word;
	logic          cfg_wr, req_take, mul_start, div_start, rsp_load, reject;

	// Register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[3] == pcg_pkg::REG_STREAM) ? {1'b0, stream_q} : seed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= pcg_pkg::RESET_SEED;
			stream_q <= pcg_pkg::RESET_SEQ;
		end else if (cfg_wr) begin
			unique case (paddr[3])
				pcg_pkg::REG_SEED:   seed_q   <= pwdata;
				pcg_pkg::REG_STREAM: stream_q <= pwdata[pcg_pkg::SEQ_W-1:0];
			endcase
		end
	end

	// Shared units
	pcg_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.state  (lcg_q),
		.inc    (inc_q),
		.stat   (mul_st),
		.result (mul_result)
	);

	pcg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (bound_q),
		.stat   (div_st),
		.rem    (div_rem)
	);

	assign word   = pcg_pkg::xsh_rr(lcg_q);
	assign reject = draw_q < thresh_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pcg_pkg::ST_IDLE: begin
				if (req_valid) begin
					if (op == pcg_pkg::OP_BOUNDED)
						state_d = (bound == '0) ? pcg_pkg::ST_DONE : pcg_pkg::ST_THRESH;
					else
						state_d = pcg_pkg::ST_MUL;
				end
			end
			pcg_pkg::ST_MUL: state_d = pcg_pkg::ST_MUL_WAIT;
			pcg_pkg::ST_MUL_WAIT: begin
				if (mul_st.done) begin
					if (more_q)
						state_d = pcg_pkg::ST_MUL;
					else if (op_q == pcg_pkg::OP_BOUNDED)
						state_d = pcg_pkg::ST_CHECK;
					else
						state_d = pcg_pkg::ST_DONE;
				end
			end
			pcg_pkg::ST_THRESH: state_d = pcg_pkg::ST_THRESH_WAIT;
			pcg_pkg::ST_THRESH_WAIT: begin
				if (div_st.done)
					state_d = pcg_pkg::ST_MUL;
			end
			pcg_pkg::ST_CHECK: state_d = reject ? pcg_pkg::ST_MUL : pcg_pkg::ST_MOD_WAIT;
			pcg_pkg::ST_MOD_WAIT: begin
				if (div_st.done)
					state_d = pcg_pkg::ST_DONE;
			end
			pcg_pkg::ST_DONE: begin
				if (rsp_load)
					state_d = pcg_pkg::ST_IDLE;
			end
			default: state_d = pcg_pkg::ST_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		req_stall = (state_q != pcg_pkg::ST_IDLE);
		req_take  = req_valid && !req_stall;
		mul_start = (state_q == pcg_pkg::ST_MUL);
		div_start = (state_q == pcg_pkg::ST_THRESH) ||
			((state_q == pcg_pkg::ST_CHECK) && !reject);
		div_num   = (state_q == pcg_pkg::ST_THRESH) ? (W'(0) - bound_q) : draw_q;
		rsp_load  = (state_q == pcg_pkg::ST_DONE) && (!rsp_valid_q || !rsp_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pcg_pkg::ST_IDLE;
			lcg_q       <= pcg_pkg::RESET_STATE;
			inc_q       <= pcg_pkg::RESET_INC;
			more_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (req_take) begin
				more_q <= (op == pcg_pkg::OP_NEXT64) || (op == pcg_pkg::OP_BOUNDED);
				if (op == pcg_pkg::OP_RESEED) begin
					// The first step from a zero state just leaves the increment.
					inc_q <= {stream_q, 1'b1};
					lcg_q <= {stream_q, 1'b1} + seed_q;
				end
			end else if (state_q == pcg_pkg::ST_MUL_WAIT && mul_st.done) begin
				lcg_q  <= mul_result;
				more_q <= 1'b0;
			end else if (state_q == pcg_pkg::ST_THRESH_WAIT && div_st.done) begin
				more_q <= 1'b1;
			end else if (state_q == pcg_pkg::ST_CHECK && reject) begin
				more_q <= 1'b1;
			end
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			op_q         <= pcg_pkg::op_t'(op);
			bound_q      <= bound;
			res_value_q  <= '0;
			res_status_q <= (op == pcg_pkg::OP_BOUNDED) && (bound == '0);
		end
		if (state_q == pcg_pkg::ST_MUL_WAIT && mul_st.done) begin
			draw_q <= {draw_q[HW-1:0], word};
			if (!more_q) begin
				unique case (op_q)
					pcg_pkg::OP_RESEED:  res_value_q <= '0;
					pcg_pkg::OP_NEXT32:  res_value_q <= {{HW{1'b0}}, word};
					pcg_pkg::OP_NEXT64:  res_value_q <= {draw_q[HW-1:0], word};
					pcg_pkg::OP_BOUNDED: res_value_q <= res_value_q;
				endcase
			end
		end
		if (state_q == pcg_pkg::ST_THRESH_WAIT && div_st.done)
			thresh_q <= div_rem;
		if (state_q == pcg_pkg::ST_MOD_WAIT && div_st.done)
			res_value_q <= div_rem;
		if (rsp_load) begin
			rsp_value_q  <= res_value_q;
			rsp_status_q <= res_status_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign value     = rsp_value_q;
	assign status    = rsp_status_q;

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_st.busy && div_st.busy))
		else $error("step unit and remainder unit busy together");
	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_st.done |-> state_q == pcg_pkg::ST_MUL_WAIT)
		else $error("step finished outside its wait state");
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |->
		(state_q == pcg_pkg::ST_THRESH_WAIT || state_q == pcg_pkg::ST_MOD_WAIT))
		else $error("remainder finished outside its wait states");
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_status_q) |-> rsp_value_q == '0)
		else $error("error beat carries a non-zero value");

endmodule
`default_nettype wire
